### sv/wasm_stack_machine_step_defines.svh
// Assertion macros shared by the checker of the stack machine step block.
`ifndef WASM_STACK_MACHINE_STEP_DEFINES_SVH
`define WASM_STACK_MACHINE_STEP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and muted during reset.
`define WSM_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stack machine check failed");

// Next-cycle implication, sampled on the rising clock edge and muted during reset.
`define WSM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stack machine check failed");

`endif

### sv/wsm_pkg.sv
// Shared types, codes and constants of the stack machine step block.
`timescale 1ns / 1ps

package wsm_pkg;

	// Default sizes of the local slot store and the value stack.
	localparam int WSM_MAX_LOCALS  = 32;
	localparam int WSM_STACK_DEPTH = 256;

	// Entries of the queue between front and back; kept a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPW         = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	// Request kinds.
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_CODE  = 2'd2;

	// Opcode bytes.
	localparam logic [7:0] OP_UNREACHABLE = 8'h00;
	localparam logic [7:0] OP_NOP         = 8'h01;
	localparam logic [7:0] OP_END         = 8'h0B;
	localparam logic [7:0] OP_LOCAL_GET   = 8'h20;
	localparam logic [7:0] OP_I32_ADD     = 8'h6A;

	// Value types.
	localparam logic [1:0] TY_I32 = 2'd0;

	// Result status codes.
	localparam logic [3:0] ST_OK     = 4'd0;
	localparam logic [3:0] ST_END    = 4'd1;
	localparam logic [3:0] ST_UNDER  = 4'd2;
	localparam logic [3:0] ST_TYPE   = 4'd3;
	localparam logic [3:0] ST_INDEX  = 4'd4;
	localparam logic [3:0] ST_OPCODE = 4'd5;
	localparam logic [3:0] ST_LEB    = 4'd6;
	localparam logic [3:0] ST_OVER   = 4'd7;
	localparam logic [3:0] ST_HALTED = 4'd8;

	// Opcode class as decided by the front.
	typedef enum logic [2:0] {
		OPC_NOP,
		OPC_END,
		OPC_GET,
		OPC_ADD,
		OPC_BAD
	} opc_t;

	// One classified beat as it travels through the queue.
	typedef struct packed {
		logic [1:0]  req;
		opc_t        op;
		logic        leb_more;
		logic        leb_hi;
		logic [7:0]  code_byte;
		logic [4:0]  local_index;
		logic [63:0] local_value;
		logic [1:0]  local_type;
	} wsm_entry_t;

endpackage

### sv/wsm_front.sv
// Front of the stack machine: accepts request beats and classifies code bytes.
`timescale 1ns / 1ps

module wsm_front import wsm_pkg::*; (
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  code_byte,
	input  logic [4:0]  local_index,
	input  logic [63:0] local_value,
	input  logic [1:0]  local_type,
	input  logic        q_full,
	output logic        q_push,
	output wsm_entry_t  q_entry
);

	opc_t op;

	// Back-pressure comes straight from the queue fill state.
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	// Opcode classification; immediate bytes are told apart later by the phase.
	always_comb begin
		case (code_byte)
			OP_UNREACHABLE, OP_NOP: op = OPC_NOP;
			OP_END:                 op = OPC_END;
			OP_LOCAL_GET:           op = OPC_GET;
			OP_I32_ADD:             op = OPC_ADD;
			default:                op = OPC_BAD;
		endcase
	end

	// LEB128 flags: continuation bit and any of the top four bits.
	always_comb begin
		q_entry.req         = req_type;
		q_entry.op          = op;
		q_entry.leb_more    = code_byte[7];
		q_entry.leb_hi      = |code_byte[7:4];
		q_entry.code_byte   = code_byte;
		q_entry.local_index = local_index;
		q_entry.local_value = local_value;
		q_entry.local_type  = local_type;
	end

endmodule

### sv/wsm_queue.sv
// Short queue of classified beats between the front and the back.
`timescale 1ns / 1ps

module wsm_queue import wsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  wsm_entry_t push_entry,
	output logic       full,
	output logic       head_valid,
	output wsm_entry_t head,
	input  logic       pop
);

	wsm_entry_t           entries_q [QUEUE_DEPTH];
	logic [QPW-1:0]       wr_ptr_q;
	logic [QPW-1:0]       rd_ptr_q;
	logic [QCW-1:0]       count_q;

	assign full       = (count_q == QCW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### sv/wsm_back.sv
// Back of the stack machine: executes queued beats on the value stack.
`timescale 1ns / 1ps

module wsm_back import wsm_pkg::*; #(
	parameter int MAX_LOCALS  = WSM_MAX_LOCALS,
	parameter int STACK_DEPTH = WSM_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  wsm_entry_t  q_head,
	output logic        q_pop,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [3:0]  status,
	output logic [63:0] top_value,
	output logic [1:0]  top_type,
	output logic [8:0]  stack_depth
);

	localparam int LAW = (MAX_LOCALS > 1) ? $clog2(MAX_LOCALS) : 1;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	// Sequencer: take a beat and read memories, then execute.
	localparam logic SEQ_TAKE = 1'b0;
	localparam logic SEQ_EXEC = 1'b1;

	// Execution phases.
	localparam logic [1:0] PH_HALTED = 2'd0;
	localparam logic [1:0] PH_RUN    = 2'd1;
	localparam logic [1:0] PH_INDEX  = 2'd2;

	logic             seq_q;
	logic [1:0]       phase_q;
	logic [SPW-1:0]   sp_q;
	logic [31:0]      acc_q;
	logic [2:0]       cnt_q;
	logic [63:0]      top_val_q;
	logic [1:0]       top_type_q;
	logic [5:0]       local_count_q;

	wsm_entry_t       ex_s1;
	logic [31:0]      acc_s1;
	logic [65:0]      local_rd_s1;
	logic [65:0]      stack_rd_s1;

	logic [65:0]      local_mem [MAX_LOCALS];
	logic [65:0]      stack_mem [STACK_DEPTH];

	logic             rsp_valid_q;
	logic [3:0]       status_q;
	logic [63:0]      top_value_q;
	logic [1:0]       top_type_q_out;
	logic [8:0]       stack_depth_q;

	logic             take;
	logic             out_free;
	logic             exec_fire;
	logic [31:0]      acc_nx;

	logic [3:0]       st;
	logic [SPW-1:0]   sp_d;
	logic [63:0]      top_val_d;
	logic [1:0]       top_type_d;
	logic [1:0]       phase_d;
	logic [2:0]       cnt_d;
	logic [31:0]      acc_d;
	logic             lw_en;
	logic             sw_en;
	logic             finish;

	// Narrow types keep only their low word.
	function automatic logic [63:0] fit_value(input logic [63:0] v, input logic [1:0] ty);
		fit_value = ty[0] ? v : {32'd0, v[31:0]};
	endfunction

	assign take      = (seq_q == SEQ_TAKE) && q_valid;
	assign q_pop     = take;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign exec_fire = (seq_q == SEQ_EXEC) && out_free;

	// Index accumulator with the incoming immediate byte merged in.
	always_comb begin
		case (cnt_q)
			3'd0:    acc_nx = acc_q | {25'd0, q_head.code_byte[6:0]};
			3'd1:    acc_nx = acc_q | {18'd0, q_head.code_byte[6:0], 7'd0};
			3'd2:    acc_nx = acc_q | {11'd0, q_head.code_byte[6:0], 14'd0};
			3'd3:    acc_nx = acc_q | {4'd0, q_head.code_byte[6:0], 21'd0};
			default: acc_nx = acc_q | {q_head.code_byte[3:0], 28'd0};
		endcase
	end

	// Local slot store: loads write, local.get reads are registered when a beat is taken.
	always_ff @(posedge clk) begin
		if (lw_en) begin
			local_mem[LAW'(ex_s1.local_index)] <= {ex_s1.local_type, ex_s1.local_value};
		end
		if (take) begin
			local_rd_s1 <= local_mem[acc_nx[LAW-1:0]];
		end
	end

	// Stack store holds every entry below the cached top.
	always_ff @(posedge clk) begin
		if (sw_en) begin
			stack_mem[SAW'(sp_q - SPW'(1))] <= {top_type_q, top_val_q};
		end
		if (take) begin
			stack_rd_s1 <= stack_mem[SAW'(sp_q - SPW'(2))];
		end
	end

	// Execution of one beat against the current machine state.
	always_comb begin
		st         = ST_OK;
		sp_d       = sp_q;
		top_val_d  = top_val_q;
		top_type_d = top_type_q;
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		acc_d      = acc_q;
		lw_en      = 1'b0;
		sw_en      = 1'b0;
		finish     = 1'b0;
		case (ex_s1.req)
			REQ_LOAD: begin
				lw_en = exec_fire && ({27'd0, ex_s1.local_index} < 32'(MAX_LOCALS));
			end
			REQ_START: begin
				sp_d    = '0;
				acc_d   = '0;
				cnt_d   = '0;
				phase_d = PH_RUN;
			end
			REQ_CODE: begin
				case (phase_q)
					PH_INDEX: begin
						acc_d = acc_s1;
						if (cnt_q >= 3'd4) begin
							if (ex_s1.leb_hi) begin
								st = ST_LEB;
							end else begin
								finish = 1'b1;
							end
						end else if (ex_s1.leb_more) begin
							cnt_d = cnt_q + 3'd1;
						end else begin
							finish = 1'b1;
						end
					end
					PH_RUN: begin
						case (ex_s1.op)
							OPC_NOP: st = ST_OK;
							OPC_END: st = ST_END;
							OPC_GET: begin
								acc_d   = '0;
								cnt_d   = '0;
								phase_d = PH_INDEX;
							end
							OPC_ADD: begin
								if (sp_q < SPW'(2)) begin
									st = ST_UNDER;
								end else if (top_type_q != TY_I32 ||
										stack_rd_s1[65:64] != TY_I32) begin
									st = ST_TYPE;
								end else begin
									top_val_d  = {32'd0, top_val_q[31:0] + stack_rd_s1[31:0]};
									top_type_d = TY_I32;
									sp_d       = sp_q - SPW'(1);
								end
							end
							default: st = ST_OPCODE;
						endcase
					end
					default: st = ST_HALTED;
				endcase
			end
			default: st = ST_OK;
		endcase

		// Last immediate byte: range check, then push the local slot.
		if (finish) begin
			if (acc_s1 >= {26'd0, local_count_q} || acc_s1 >= 32'(MAX_LOCALS)) begin
				st = ST_INDEX;
			end else if (sp_q >= SPW'(STACK_DEPTH)) begin
				st = ST_OVER;
			end else begin
				sw_en      = exec_fire && (sp_q != '0);
				top_val_d  = fit_value(local_rd_s1[63:0], local_rd_s1[65:64]);
				top_type_d = local_rd_s1[65:64];
				sp_d       = sp_q + SPW'(1);
				phase_d    = PH_RUN;
			end
		end

		// Any non-ok code byte stops execution until the next start.
		if (ex_s1.req == REQ_CODE && st != ST_OK) begin
			phase_d = PH_HALTED;
		end
	end

	// Sequencer and machine state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q         <= SEQ_TAKE;
			phase_q       <= PH_HALTED;
			sp_q          <= '0;
			acc_q         <= '0;
			cnt_q         <= '0;
			local_count_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				local_count_q <= cfg_wr_data;
			end
			if (take) begin
				seq_q <= SEQ_EXEC;
			end else if (exec_fire) begin
				seq_q   <= SEQ_TAKE;
				phase_q <= phase_d;
				sp_q    <= sp_d;
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
			end
		end
	end

	// Beat and cached top registers.
	always_ff @(posedge clk) begin
		if (take) begin
			ex_s1  <= q_head;
			acc_s1 <= acc_nx;
		end
		if (exec_fire) begin
			top_val_q  <= top_val_d;
			top_type_q <= top_type_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q       <= st;
			top_value_q    <= (sp_d != '0) ? top_val_d : 64'd0;
			top_type_q_out <= (sp_d != '0) ? top_type_d : 2'd0;
			stack_depth_q  <= 9'(sp_d);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign top_value   = top_value_q;
	assign top_type    = top_type_q_out;
	assign stack_depth = stack_depth_q;

endmodule

### sv/wasm_stack_machine_step.sv
// Top level of the stack machine step block: front, queue and back.
`timescale 1ns / 1ps
// The back takes one beat from the queue, registering it with the stack and local
// store reads, then executes it into the output register, stalling while a held
// result is not yet accepted; it takes no new beat before the last is executed.
// Request beats are taken on consecutive cycles until the two-entry queue fills.
// Reset clears control state; the machine starts halted, stack empty,
// local_count zero. Stack and local stores are not cleared.

module wasm_stack_machine_step import wsm_pkg::*; #(
	parameter int MAX_LOCALS  = WSM_MAX_LOCALS,
	parameter int STACK_DEPTH = WSM_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  code_byte,
	input  logic [4:0]  local_index,
	input  logic [63:0] local_value,
	input  logic [1:0]  local_type,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [3:0]  status,
	output logic [63:0] top_value,
	output logic [1:0]  top_type,
	output logic [8:0]  stack_depth
);

	logic       q_full;
	logic       q_push;
	wsm_entry_t q_entry;
	logic       q_valid;
	wsm_entry_t q_head;
	logic       q_pop;

	wsm_front u_front (
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.code_byte   (code_byte),
		.local_index (local_index),
		.local_value (local_value),
		.local_type  (local_type),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	wsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	wsm_back #(
		.MAX_LOCALS  (MAX_LOCALS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.top_value   (top_value),
		.top_type    (top_type),
		.stack_depth (stack_depth)
	);

endmodule

### sv/wsm_checker.sv
// Port-level checks of the stack machine step block and their binding.
`timescale 1ns / 1ps
`include "wasm_stack_machine_step_defines.svh"

module wsm_checker import wsm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [3:0]  status,
	input logic [63:0] top_value,
	input logic [1:0]  top_type,
	input logic [8:0]  stack_depth
);

	// A stalled result beat stays and keeps its payload.
	`WSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
	`WSM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(status) && $stable(top_value) && $stable(top_type) && $stable(stack_depth))

	// An empty stack shows a zero top.
	`WSM_ASSERT_NOW(a_empty_top, rsp_valid && stack_depth == 9'd0, top_value == 64'd0 && top_type == 2'd0)

	// Failed adds leave the stack as it was.
	`WSM_ASSERT_NOW(a_under_depth, rsp_valid && status == ST_UNDER, stack_depth < 9'd2)
	`WSM_ASSERT_NOW(a_type_depth, rsp_valid && status == ST_TYPE, stack_depth >= 9'd2)

endmodule

bind wasm_stack_machine_step wsm_checker u_wsm_checker (.*);
